FILE: rtl/core/bru_pkg.sv
`default_nettype none

package bru_pkg;

  // Event codes carried by the cmd field of a request.
  localparam logic [2:0] CMD_INTERVAL_START = 3'd0;
  localparam logic [2:0] CMD_WORK_START     = 3'd1;
  localparam logic [2:0] CMD_WORK_FINISH    = 3'd2;
  localparam logic [2:0] CMD_ADD_OVERHEAD   = 3'd3;
  localparam logic [2:0] CMD_INTERVAL_END   = 3'd4;

  // Result kinds.
  localparam logic KIND_DURATION = 1'b0;
  localparam logic KIND_RATIO    = 1'b1;

  // Register word index on the configuration port.
  localparam logic REG_UNIT_COUNT = 1'b0;

  localparam int unsigned TIME_W    = 64;
  localparam int unsigned RATIO_W   = 17;
  localparam int unsigned DIV_STEPS = 17;
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
  localparam logic [4:0] UNIT_COUNT_RESET  = 5'd16;
  localparam logic [4:0] MAX_REPORTS       = 5'd16;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [TIME_W-1:0] value;
    logic              ge;     // a >= b, valid for a subtraction
  } alu_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/per_unit_busy_ratio_monitor.sv
// Work start, add overhead, interval start and unused codes: captured in idle, done in exec.
// Work finish: exec, add and emit steps; the next request is accepted once back in idle.
// Interval end: exec and length steps, then per unit: unit, compare, division and round
// if needed (one 64-bit adder walks a 17-step restoring division); emit waits on out_stall.
// Synchronous reset clears all per-unit records at once and sets unit_count to 16;
// there is no clearing pass.
`default_nettype none

module per_unit_busy_ratio_monitor #(
  parameter int unsigned NUM_UNITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  cmd,
  input  wire logic [63:0] now,
  input  wire logic [3:0]  unit_index,
  input  wire logic [63:0] overhead_amount,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             kind,
  output logic [3:0]       unit_id,
  output logic [63:0]      duration,
  output logic [16:0]      ratio,
  output logic             last,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import bru_pkg::*;

  // Only units 0 to 15 can be addressed by a 4-bit index, so the tables hold
  // at most sixteen entries.
  localparam int unsigned DEPTH = (NUM_UNITS < 16) ? NUM_UNITS : 16;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [4:0]  DEPTH_C = 5'(DEPTH);
  localparam logic [6:0]  NUM_UNITS_C = 7'(NUM_UNITS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_EXEC  = 4'd1;
  localparam logic [3:0] ST_FADD  = 4'd2;
  localparam logic [3:0] ST_LEN   = 4'd3;
  localparam logic [3:0] ST_UNIT  = 4'd4;
  localparam logic [3:0] ST_CMP   = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_ROUND = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0] state;

  // The request is captured on acceptance and worked on from these registers.
  logic [2:0]  cmd_r;
  logic [63:0] now_r;
  logic [3:0]  idx_r;
  logic [63:0] amt_r;

  logic [4:0] unit_count;
  logic [63:0] interval_start;

  // Per-unit tables. An entry whose valid bit is clear reads as zero, which
  // lets the interval start clear every record at once.
  logic [63:0]      work_begin     [DEPTH];
  logic [63:0]      busy_total     [DEPTH];
  logic [63:0]      overhead_total [DEPTH];
  logic [DEPTH-1:0] wb_v;
  logic [DEPTH-1:0] busy_v;
  logic [DEPTH-1:0] ovh_v;

  // Working registers of the ratio walk and the finish path.
  logic [4:0]         ptr;
  logic [4:0]         n_r;
  logic [63:0]        dur_r;
  logic [63:0]        len_r;
  logic [63:0]        den_r;
  logic [63:0]        busy_r;
  logic               ovh_ge_r;
  logic [63:0]        rem_r;
  logic [16:0]        quo_r;
  logic [4:0]         div_cnt;
  logic [RATIO_W-1:0] ratio_r;

  logic [AW-1:0] addr;
  logic [63:0]   wb_rd;
  logic [63:0]   busy_rd;
  logic [63:0]   ovh_rd;
  logic          idx_ok;
  logic [4:0]    n_sel;
  logic          out_free;
  logic          cfg_wr;
  logic          div_ge;

  logic [63:0] alu_a;
  logic [63:0] alu_b;
  alu_op_t     alu_op;
  alu_res_t    alu_res;

  assign in_stall = (state != ST_IDLE);
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_UNIT_COUNT) ? {27'd0, unit_count} : 32'd0;
  assign out_free = !out_valid || !out_stall;

  // During the ratio walk the tables are read at the walk pointer, otherwise at
  // the unit that the request names.
  always_comb begin
    if (cmd_r == CMD_INTERVAL_END) begin
      addr = ptr[AW-1:0];
    end else begin
      addr = idx_r[AW-1:0];
    end
  end

  assign idx_ok  = ({3'd0, idx_r} < NUM_UNITS_C);
  assign wb_rd   = wb_v[addr]   ? work_begin[addr]     : 64'd0;
  assign busy_rd = busy_v[addr] ? busy_total[addr]     : 64'd0;
  assign ovh_rd  = ovh_v[addr]  ? overhead_total[addr] : 64'd0;
  assign n_sel   = (unit_count > DEPTH_C) ? DEPTH_C : unit_count;

  // Operand selection for the shared adder, one use per sequencer step.
  always_comb begin
    alu_a  = 64'd0;
    alu_b  = 64'd0;
    alu_op = ALU_ADD;
    unique case (state)
      ST_EXEC: begin
        if (cmd_r == CMD_WORK_FINISH) begin
          alu_a  = now_r;
          alu_b  = wb_rd;
          alu_op = ALU_SUB;
        end else begin
          alu_a  = ovh_rd;
          alu_b  = amt_r;
        end
      end
      ST_FADD: begin
        alu_a = busy_rd;
        alu_b = dur_r;
      end
      ST_LEN: begin
        alu_a  = now_r;
        alu_b  = interval_start;
        alu_op = ALU_SUB;
      end
      ST_UNIT: begin
        alu_a  = len_r;
        alu_b  = ovh_rd;
        alu_op = ALU_SUB;
      end
      ST_CMP: begin
        alu_a  = busy_r;
        alu_b  = den_r;
        alu_op = ALU_SUB;
      end
      ST_DIV: begin
        alu_a  = {rem_r[62:0], 1'b0};
        alu_b  = den_r;
        alu_op = ALU_SUB;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  bru_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .res (alu_res)
  );

  // A restoring step subtracts when the shifted-out top bit is set or the
  // shifted remainder is at least the denominator.
  assign div_ge = rem_r[63] || alu_res.ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      unit_count     <= UNIT_COUNT_RESET;
      interval_start <= 64'd0;
      wb_v           <= '0;
      busy_v         <= '0;
      ovh_v          <= '0;
    end else begin
      if (cfg_wr && (paddr[2] == REG_UNIT_COUNT)) begin
        unit_count <= pwdata[4:0];
      end
      // The emit step reloads the result register itself when it is free.
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            now_r <= now;
            idx_r <= unit_index;
            amt_r <= overhead_amount;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          unique case (cmd_r)
            CMD_INTERVAL_START: begin
              interval_start <= now_r;
              wb_v           <= '0;
              busy_v         <= '0;
              ovh_v          <= '0;
              state          <= ST_IDLE;
            end
            CMD_WORK_START: begin
              if (idx_ok) begin
                work_begin[addr] <= now_r;
                wb_v[addr]       <= 1'b1;
              end
              state <= ST_IDLE;
            end
            CMD_WORK_FINISH: begin
              if (idx_ok) begin
                dur_r <= alu_res.value;
                state <= ST_FADD;
              end else begin
                state <= ST_IDLE;
              end
            end
            CMD_ADD_OVERHEAD: begin
              if (idx_ok) begin
                overhead_total[addr] <= alu_res.value;
                ovh_v[addr]          <= 1'b1;
              end
              state <= ST_IDLE;
            end
            CMD_INTERVAL_END: begin
              ptr <= 5'd0;
              n_r <= n_sel;
              if (n_sel != 5'd0) begin
                state <= ST_LEN;
              end else begin
                state <= ST_IDLE;
              end
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end
        ST_FADD: begin
          busy_total[addr] <= alu_res.value;
          busy_v[addr]     <= 1'b1;
          state            <= ST_EMIT;
        end
        ST_LEN: begin
          len_r <= alu_res.value;
          state <= ST_UNIT;
        end
        ST_UNIT: begin
          // Overhead at or above the interval length leaves no room for work.
          den_r    <= alu_res.value;
          ovh_ge_r <= !alu_res.ge || (alu_res.value == 64'd0);
          busy_r   <= busy_rd;
          state    <= ST_CMP;
        end
        ST_CMP: begin
          if (busy_r == 64'd0) begin
            ratio_r <= '0;
            state   <= ST_EMIT;
          end else if (ovh_ge_r || alu_res.ge) begin
            ratio_r <= RATIO_ONE;
            state   <= ST_EMIT;
          end else begin
            rem_r   <= busy_r;
            quo_r   <= '0;
            div_cnt <= 5'd0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r   <= div_ge ? alu_res.value : {rem_r[62:0], 1'b0};
          quo_r   <= {quo_r[15:0], div_ge};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'(DIV_STEPS - 1)) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          // Sixteen fraction bits plus a rounding bit; halves round up.
          ratio_r <= {1'b0, quo_r[16:1]} + {16'd0, quo_r[0]};
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (cmd_r == CMD_INTERVAL_END) begin
              kind     <= KIND_RATIO;
              unit_id  <= ptr[3:0];
              duration <= 64'd0;
              ratio    <= ratio_r;
              last     <= (ptr == n_r - 5'd1);
              if (ptr == n_r - 5'd1) begin
                state <= ST_IDLE;
              end else begin
                ptr   <= ptr + 5'd1;
                state <= ST_UNIT;
              end
            end else begin
              kind     <= KIND_DURATION;
              unit_id  <= idx_r;
              duration <= dur_r;
              ratio    <= '0;
              last     <= 1'b1;
              state    <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A ratio never exceeds one in Q1.16.
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (ratio <= RATIO_ONE))
    else $error("ratio above one");

  // A duration report is always the single, final result of its request.
  a_duration_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_DURATION)) |-> (last && (ratio == '0)))
    else $error("malformed duration report");

  // The walk pointer stays inside the reported unit count.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_UNIT) || (state == ST_CMP) || (state == ST_DIV)) |-> (ptr < n_r))
    else $error("walk pointer beyond unit count");

  // The division never runs past its step count.
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (div_cnt < 5'(DIV_STEPS)))
    else $error("division step overrun");

  // A result is loaded only from the emit step.
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    (!$past(out_valid) && out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside emit step");

endmodule

`default_nettype wire

FILE: rtl/core/bru_alu.sv
`default_nettype none

module bru_alu (
  input  wire logic [63:0]      a,
  input  wire logic [63:0]      b,
  input  wire bru_pkg::alu_op_t op,
  output bru_pkg::alu_res_t     res
);
  import bru_pkg::*;

  logic [TIME_W-1:0] b_eff;
  logic [TIME_W:0]   sum;

  // One 64-bit adder; subtraction is a plus the inverted b plus one.
  always_comb begin
    b_eff     = (op == ALU_SUB) ? ~b : b;
    sum       = {1'b0, a} + {1'b0, b_eff} + {{TIME_W{1'b0}}, (op == ALU_SUB)};
    res.value = sum[TIME_W-1:0];
    res.ge    = sum[TIME_W];
  end

endmodule

`default_nettype wire
